[src/vksi_pkg.sv]
package vksi_pkg;

  typedef enum logic [1:0] {
    CMD_CLEAR  = 2'd0,
    CMD_APPEND = 2'd1,
    CMD_QUERY  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  localparam logic [1:0] KIND_HOLD   = 2'd0;
  localparam logic [1:0] KIND_LIN    = 2'd1;
  localparam logic [1:0] KIND_SPLINE = 2'd2;

  localparam int DIV_STEPS = 16;
  localparam int WW        = 28;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOKUP,
    S_APP_RD,
    S_APP_WR,
    S_SRCH,
    S_SRCH_CMP,
    S_T0,
    S_T1,
    S_DIV,
    S_WGT1,
    S_WGT2,
    S_WGT3,
    S_MAC_RD,
    S_MAC_MUL,
    S_MAC_ACC,
    S_FIN
  } state_t;

  typedef enum logic [1:0] {
    A_LAST,
    A_SRCH,
    A_IDX1,
    A_MAC
  } asel_t;

  typedef struct packed {
    logic  rdy;
    logic  load;
    logic  lookup;
    logic  clear_all;
    logic  rd;
    asel_t asel;
    logic  app_wr;
    logic  srch_upd;
    logic  t0_take;
    logic  t1_take;
    logic  div_step;
    logic  w_lin;
    logic  w_sq;
    logic  w_cube;
    logic  w_spl;
    logic  mac_mul;
    logic  mac_acc;
    logic  fin;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    cmd_t cmd;
    logic bad_app;
    logic q_empty;
    logic srch_done;
    logic held;
    logic is_lin;
    logic div_done;
    logic mac_last;
    logic out_busy;
  } sts_t;

endpackage

[src/vksi_req_if.sv]
interface vksi_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [3:0]  track;
  logic [31:0] key_or_query_time;
  logic [31:0] in_x;
  logic [31:0] in_y;
  logic [31:0] in_z;

  modport source (
    output valid, cmd, track, key_or_query_time, in_x, in_y, in_z,
    input  ready
  );
  modport sink (
    input  valid, cmd, track, key_or_query_time, in_x, in_y, in_z,
    output ready
  );
endinterface

[src/vksi_rsp_if.sv]
interface vksi_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] out_x;
  logic [31:0] out_y;
  logic [31:0] out_z;
  logic [1:0]  status;
  logic [1:0]  interp_kind;

  modport source (
    output valid, out_x, out_y, out_z, status, interp_kind,
    input  ready
  );
  modport sink (
    input  valid, out_x, out_y, out_z, status, interp_kind,
    output ready
  );
endinterface

[src/vksi_ctrl.sv]
module vksi_ctrl import vksi_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  sts_t sts,
  output ctl_t ctl
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  always_comb begin
    ctl = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        // no word is taken while reset is held
        ctl.rdy = !rst;
        if (sts.in_valid && !rst) begin
          ctl.load = 1'b1;
          state_next = S_LOOKUP;
        end
      end
      S_LOOKUP: begin
        ctl.lookup = 1'b1;
        case (sts.cmd)
          CMD_CLEAR: begin
            ctl.clear_all = 1'b1;
            state_next = S_FIN;
          end
          CMD_APPEND: state_next = sts.bad_app ? S_FIN : S_APP_RD;
          CMD_QUERY: state_next = sts.q_empty ? S_FIN : S_SRCH;
          default: state_next = S_FIN;
        endcase
      end
      S_APP_RD: begin
        ctl.rd = 1'b1;
        ctl.asel = A_LAST;
        state_next = S_APP_WR;
      end
      S_APP_WR: begin
        ctl.app_wr = 1'b1;
        state_next = S_FIN;
      end
      S_SRCH: begin
        // once the range is one key wide the same read fetches the lower key
        ctl.rd = 1'b1;
        ctl.asel = A_SRCH;
        state_next = sts.srch_done ? S_T0 : S_SRCH_CMP;
      end
      S_SRCH_CMP: begin
        ctl.srch_upd = 1'b1;
        state_next = S_SRCH;
      end
      S_T0: begin
        ctl.t0_take = 1'b1;
        if (sts.held) begin
          state_next = S_MAC_RD;
        end else begin
          ctl.rd = 1'b1;
          ctl.asel = A_IDX1;
          state_next = S_T1;
        end
      end
      S_T1: begin
        ctl.t1_take = 1'b1;
        state_next = S_DIV;
      end
      S_DIV: begin
        ctl.div_step = 1'b1;
        if (sts.div_done) state_next = S_WGT1;
      end
      S_WGT1: begin
        if (sts.is_lin) begin
          ctl.w_lin = 1'b1;
          state_next = S_MAC_RD;
        end else begin
          ctl.w_sq = 1'b1;
          state_next = S_WGT2;
        end
      end
      S_WGT2: begin
        ctl.w_cube = 1'b1;
        state_next = S_WGT3;
      end
      S_WGT3: begin
        ctl.w_spl = 1'b1;
        state_next = S_MAC_RD;
      end
      S_MAC_RD: begin
        ctl.rd = 1'b1;
        ctl.asel = A_MAC;
        state_next = S_MAC_MUL;
      end
      S_MAC_MUL: begin
        ctl.mac_mul = 1'b1;
        state_next = S_MAC_ACC;
      end
      S_MAC_ACC: begin
        ctl.mac_acc = 1'b1;
        state_next = sts.mac_last ? S_FIN : S_MAC_RD;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          ctl.fin = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

[src/vksi_dp.sv]
module vksi_dp import vksi_pkg::*; #(
  parameter int TRACKS = 16,
  parameter int KEYS_PER_TRACK = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  ctl_t        ctl,
  output sts_t        sts,
  vksi_req_if.sink    req,
  vksi_rsp_if.source  rsp
);

  localparam int TW    = (TRACKS > 1) ? $clog2(TRACKS) : 1;
  localparam int CW    = $clog2(KEYS_PER_TRACK + 1);
  localparam int KW    = $clog2(KEYS_PER_TRACK);
  localparam int DEPTH = TRACKS * KEYS_PER_TRACK;
  localparam int AW    = $clog2(DEPTH);
  localparam int WL    = 54;
  localparam int DCW   = $clog2(DIV_STEPS);

  // key stores, track-major
  logic [31:0] tmem [DEPTH];
  logic [31:0] xmem [DEPTH];
  logic [31:0] ymem [DEPTH];
  logic [31:0] zmem [DEPTH];
  logic [CW-1:0] cnt [TRACKS];

  logic [1:0]  op_cmd;
  logic [3:0]  op_trk;
  logic [31:0] op_tm, op_x, op_y, op_z;
  logic [CW-1:0] n, lo, hi, p;
  logic [31:0] t_q, x_q, y_q, z_q;
  logic [31:0] t_lo, den, rem;
  logic [15:0] q;
  logic [DCW-1:0] dcnt;
  logic [31:0] u2;
  logic [47:0] u3;
  logic signed [WW-1:0] w [4];
  logic [1:0] kcnt, klast;
  logic lin_sh, has_val;
  logic [1:0] st_w, kind;
  logic signed [59:0] px, py, pz;
  logic signed [63:0] acc_x, acc_y, acc_z;
  logic ovalid;
  logic [31:0] ox, oy, oz;
  logic [1:0] ost, okind;

  logic [TW-1:0] trk_idx;
  logic trk_ok;
  logic [CW-1:0] n_cur, mid, koff;
  logic [AW-1:0] base, raddr, waddr;
  logic [31:0] wr_tm;
  logic [15:0] u;
  logic [32:0] r2;
  logic ge;
  logic [WL-1:0] e1, e2, e3, c48, w0l, w1l, w2l, w3l;

  function automatic logic signed [WW-1:0] rnd24(input logic [WL-1:0] v);
    logic [WL-1:0] t;
    begin
      t = v + (WL'(1) << 23);
      return WW'($signed(t) >>> 24);
    end
  endfunction

  function automatic logic [31:0] fin_val(input logic signed [63:0] a, input logic lin);
    logic signed [63:0] s;
    begin
      if (lin) s = (a + 64'sd32768) >>> 16;
      else s = (a + 64'sd16777216) >>> 25;
      if (s > 64'sd2147483647) return 32'h7fffffff;
      else if (s < -64'sd2147483648) return 32'h80000000;
      else return s[31:0];
    end
  endfunction

  assign trk_idx = TW'(op_trk);
  assign trk_ok  = ({5'd0, op_trk} < 9'(TRACKS));
  assign n_cur   = trk_ok ? cnt[trk_idx] : '0;
  assign base    = AW'(trk_idx) * AW'(KEYS_PER_TRACK);
  assign mid     = lo + ((hi - lo) >> 1);

  always_comb begin
    case (ctl.asel)
      A_LAST: koff = n - CW'(1);
      A_SRCH: koff = sts.srch_done ? lo : mid;
      A_IDX1: koff = lo + CW'(1);
      A_MAC:  koff = p + CW'(kcnt);
      default: koff = lo;
    endcase
  end

  assign raddr = base + AW'(koff[KW-1:0]);
  assign waddr = base + AW'(n[KW-1:0]);
  // a key earlier than the track's last one is raised to it
  assign wr_tm = (n != '0 && op_tm < t_q) ? t_q : op_tm;

  assign u  = (den == '0) ? 16'd0 : q;
  assign r2 = {rem, 1'b0};
  assign ge = (r2 >= {1'b0, den});

  // twice the catmull-rom weights, in q.48
  assign e1  = WL'(u) << 32;
  assign e2  = WL'(u2) << 16;
  assign e3  = WL'(u3);
  assign c48 = WL'(1) << 49;
  assign w0l = e2 + e2 - e3 - e1;
  assign w1l = e3 + (e3 << 1) - (e2 << 2) - e2 + c48;
  assign w2l = (e2 << 2) + e1 - e3 - (e3 << 1);
  assign w3l = e3 - e2;

  assign sts.in_valid  = req.valid;
  assign sts.cmd       = cmd_t'(op_cmd);
  assign sts.bad_app   = !trk_ok || (n_cur >= CW'(KEYS_PER_TRACK));
  assign sts.q_empty   = (n_cur == '0);
  assign sts.srch_done = ((hi - lo) <= CW'(1));
  assign sts.held      = (lo == n - CW'(1)) || (lo == '0 && op_tm < t_q);
  assign sts.is_lin    = (lo == '0) || (lo == n - CW'(2));
  assign sts.div_done  = (dcnt == DCW'(DIV_STEPS - 1));
  assign sts.mac_last  = (kcnt == klast);
  assign sts.out_busy  = ovalid && !rsp.ready;

  assign req.ready       = ctl.rdy;
  assign rsp.valid       = ovalid;
  assign rsp.out_x       = ox;
  assign rsp.out_y       = oy;
  assign rsp.out_z       = oz;
  assign rsp.status      = ost;
  assign rsp.interp_kind = okind;

  always_ff @(posedge clk) begin
    if (ctl.rd) begin
      t_q <= tmem[raddr];
      x_q <= xmem[raddr];
      y_q <= ymem[raddr];
      z_q <= zmem[raddr];
    end
    if (ctl.app_wr) begin
      tmem[waddr] <= wr_tm;
      xmem[waddr] <= op_x;
      ymem[waddr] <= op_y;
      zmem[waddr] <= op_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TRACKS; i++) cnt[i] <= '0;
    end else if (ctl.clear_all) begin
      for (int i = 0; i < TRACKS; i++) cnt[i] <= '0;
    end else if (ctl.app_wr) begin
      cnt[trk_idx] <= n + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      op_cmd  <= req.cmd;
      op_trk  <= req.track;
      op_tm   <= req.key_or_query_time;
      op_x    <= req.in_x;
      op_y    <= req.in_y;
      op_z    <= req.in_z;
      st_w    <= ST_OK;
      kind    <= KIND_HOLD;
      has_val <= 1'b0;
    end
    if (ctl.lookup) begin
      n  <= n_cur;
      lo <= '0;
      hi <= n_cur;
      if (cmd_t'(op_cmd) == CMD_APPEND && sts.bad_app) st_w <= ST_FULL;
      if (cmd_t'(op_cmd) == CMD_QUERY && sts.q_empty) st_w <= ST_EMPTY;
    end
    if (ctl.srch_upd) begin
      if (op_tm < t_q) hi <= mid;
      else lo <= mid;
    end
    if (ctl.t0_take) begin
      t_lo <= t_q;
      if (sts.held) begin
        w[0]    <= WW'(32'd65536);
        p       <= lo;
        klast   <= 2'd0;
        lin_sh  <= 1'b1;
        has_val <= 1'b1;
        kcnt    <= '0;
        acc_x   <= '0;
        acc_y   <= '0;
        acc_z   <= '0;
      end
    end
    if (ctl.t1_take) begin
      den  <= t_q - t_lo;
      rem  <= op_tm - t_lo;
      q    <= '0;
      dcnt <= '0;
    end
    if (ctl.div_step) begin
      rem  <= ge ? 32'(r2 - {1'b0, den}) : r2[31:0];
      q    <= {q[14:0], ge};
      dcnt <= dcnt + DCW'(1);
    end
    if (ctl.w_lin) begin
      w[0]    <= WW'(17'h10000 - 17'(u));
      w[1]    <= WW'(u);
      p       <= lo;
      klast   <= 2'd1;
      lin_sh  <= 1'b1;
      kind    <= KIND_LIN;
      has_val <= 1'b1;
      kcnt    <= '0;
      acc_x   <= '0;
      acc_y   <= '0;
      acc_z   <= '0;
    end
    if (ctl.w_sq) u2 <= 32'(u) * 32'(u);
    if (ctl.w_cube) u3 <= 48'(u2) * 48'(u);
    if (ctl.w_spl) begin
      w[0]    <= rnd24(w0l);
      w[1]    <= rnd24(w1l);
      w[2]    <= rnd24(w2l);
      w[3]    <= rnd24(w3l);
      p       <= lo - CW'(1);
      klast   <= 2'd3;
      lin_sh  <= 1'b0;
      kind    <= KIND_SPLINE;
      has_val <= 1'b1;
      kcnt    <= '0;
      acc_x   <= '0;
      acc_y   <= '0;
      acc_z   <= '0;
    end
    if (ctl.mac_mul) begin
      px <= w[kcnt] * $signed(x_q);
      py <= w[kcnt] * $signed(y_q);
      pz <= w[kcnt] * $signed(z_q);
    end
    if (ctl.mac_acc) begin
      acc_x <= acc_x + 64'(px);
      acc_y <= acc_y + 64'(py);
      acc_z <= acc_z + 64'(pz);
      kcnt  <= kcnt + 2'd1;
    end
    if (ctl.fin) begin
      ox    <= has_val ? fin_val(acc_x, lin_sh) : '0;
      oy    <= has_val ? fin_val(acc_y, lin_sh) : '0;
      oz    <= has_val ? fin_val(acc_z, lin_sh) : '0;
      ost   <= st_w;
      okind <= kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ovalid <= 1'b0;
    else if (ctl.fin) ovalid <= 1'b1;
    else if (rsp.ready) ovalid <= 1'b0;
  end

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    ctl.div_step |=> (rem < den))
    else $error("divider remainder not below divisor");

  a_seg_range: assert property (@(posedge clk) disable iff (rst)
    ctl.t1_take |-> ((lo + CW'(1)) < n))
    else $error("interpolation segment past last key");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    ctl.fin |-> !(ovalid && !rsp.ready))
    else $error("result overwritten before taken");

endmodule

[src/vec3_keyframe_spline_interp.sv]
// Keyframe store and Catmull-Rom interpolator for 3-vectors in Q16.16, one word at a time. A query
// binary-searches the track's key times through the single read port of the key memory, a read
// and a compare step per halving, divides for the 16-bit segment fraction, then reads the 1, 2
// or 4 neighbor keys and accumulates them through three multipliers, with a read, a multiply and
// an accumulate step per key. A finished result sits in an output register, so the next word is
// taken while it waits.
module vec3_keyframe_spline_interp import vksi_pkg::*; #(
  parameter int TRACKS = 16,
  parameter int KEYS_PER_TRACK = 256
) (
  input  logic       clk,
  input  logic       rst,
  vksi_req_if.sink   req,
  vksi_rsp_if.source rsp
);

  ctl_t ctl;
  sts_t sts;

  vksi_ctrl u_ctrl (
    .clk (clk),
    .rst (rst),
    .sts (sts),
    .ctl (ctl)
  );

  vksi_dp #(
    .TRACKS         (TRACKS),
    .KEYS_PER_TRACK (KEYS_PER_TRACK)
  ) u_dp (
    .clk (clk),
    .rst (rst),
    .ctl (ctl),
    .sts (sts),
    .req (req),
    .rsp (rsp)
  );

endmodule

[tb/tb_top.sv]
module tb_top;
  import vksi_pkg::*;

  localparam int NTRK = 16;
  localparam int NKEY = 256;

  typedef struct {
    logic [1:0]  cmd;
    logic [3:0]  track;
    logic [31:0] t;
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } word_t;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  status;
    logic [1:0]  kind;
  } vec_out_t;

  logic clk;
  logic rst;

  vksi_req_if req ();
  vksi_rsp_if rsp ();

  vec3_keyframe_spline_interp #(.TRACKS(NTRK), .KEYS_PER_TRACK(NKEY)) dut (
    .clk(clk),
    .rst(rst),
    .req(req.sink),
    .rsp(rsp.source)
  );

  // predictor copy of the key stores
  logic [31:0] kt  [NTRK][NKEY];
  logic signed [31:0] kx [NTRK][NKEY];
  logic signed [31:0] ky [NTRK][NKEY];
  logic signed [31:0] kz [NTRK][NKEY];
  int          kcnt [NTRK];

  word_t    pending_words[$];
  vec_out_t expected_vals[$];
  int       errors;
  int       n_sent, n_got, n_hold, n_lin, n_spl, n_full, n_empty;

  function automatic logic signed [31:0] sat32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic longint lerp_q16(logic signed [31:0] a, logic signed [31:0] b, longint u);
    longint s;
    s = longint'(a) * (65536 - u) + longint'(b) * u + 32768;
    return s >>> 16;
  endfunction

  function automatic longint seg_frac(logic [31:0] t, logic [31:0] lo, logic [31:0] hi);
    logic [31:0] den;
    logic [63:0] num;
    logic [63:0] q;
    den = hi - lo;
    num = {32'd0, t - lo} << 16;
    if (den == 0) return 0;
    q = num / {32'd0, den};
    return (q > 65535) ? 65535 : longint'(q);
  endfunction

  function automatic vec_out_t apply_word(word_t w);
    vec_out_t r;
    int n, lo, hi, mid, idx, p;
    logic [31:0] tm;
    longint u, u2, u3, q16, q32, q48;
    longint wt[4];
    longint acc;
    logic signed [31:0] v[4];
    r = '{32'd0, 32'd0, 32'd0, ST_OK, KIND_HOLD};
    tm = w.t;
    case (w.cmd)
      CMD_CLEAR: begin
        foreach (kcnt[i]) kcnt[i] = 0;
      end
      CMD_APPEND: begin
        n = kcnt[w.track];
        if (n >= NKEY) begin
          r.status = ST_FULL;
        end else begin
          if (n > 0 && tm < kt[w.track][n-1]) tm = kt[w.track][n-1];
          kt[w.track][n] = tm;
          kx[w.track][n] = w.x;
          ky[w.track][n] = w.y;
          kz[w.track][n] = w.z;
          kcnt[w.track] = n + 1;
        end
      end
      CMD_QUERY: begin
        n = kcnt[w.track];
        if (n == 0) begin
          r.status = ST_EMPTY;
        end else begin
          lo = 0;
          hi = n;
          while (hi - lo > 1) begin
            mid = lo + (hi - lo) / 2;
            if (tm < kt[w.track][mid]) hi = mid;
            else lo = mid;
          end
          idx = lo;
          if (idx == n - 1 || (idx == 0 && tm < kt[w.track][0])) begin
            r.x = kx[w.track][idx];
            r.y = ky[w.track][idx];
            r.z = kz[w.track][idx];
          end else if (idx == 0 || idx == n - 2) begin
            u = seg_frac(tm, kt[w.track][idx], kt[w.track][idx+1]);
            r.kind = KIND_LIN;
            r.x = sat32(lerp_q16(kx[w.track][idx], kx[w.track][idx+1], u));
            r.y = sat32(lerp_q16(ky[w.track][idx], ky[w.track][idx+1], u));
            r.z = sat32(lerp_q16(kz[w.track][idx], kz[w.track][idx+1], u));
          end else begin
            u = seg_frac(tm, kt[w.track][idx], kt[w.track][idx+1]);
            u2 = u * u;
            u3 = u2 * u;
            q16 = 65536;
            q32 = q16 * q16;
            q48 = q32 * q16;
            wt[0] = -u3 + 2 * u2 * q16 - u * q32;
            wt[1] = 3 * u3 - 5 * u2 * q16 + 2 * q48;
            wt[2] = -3 * u3 + 4 * u2 * q16 + u * q32;
            wt[3] = u3 - u2 * q16;
            for (int k = 0; k < 4; k++) wt[k] = (wt[k] + (64'sd1 <<< 23)) >>> 24;
            p = idx - 1;
            r.kind = KIND_SPLINE;
            for (int c = 0; c < 3; c++) begin
              for (int k = 0; k < 4; k++)
                v[k] = (c == 0) ? kx[w.track][p+k] : (c == 1) ? ky[w.track][p+k] :
                       kz[w.track][p+k];
              acc = 64'sd1 <<< 24;
              for (int k = 0; k < 4; k++) acc += wt[k] * longint'(v[k]);
              acc = acc >>> 25;
              if (c == 0) r.x = sat32(acc);
              else if (c == 1) r.y = sat32(acc);
              else r.z = sat32(acc);
            end
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // driver
  int drv_gap;
  always @(posedge clk) begin
    if (rst) begin
      req.valid <= 1'b0;
      drv_gap <= 0;
    end else if (!req.valid || req.ready) begin
      if (req.valid) begin
        expected_vals.insert(expected_vals.size(),
                             apply_word('{req.cmd, req.track, req.key_or_query_time,
                                          req.in_x, req.in_y, req.in_z}));
        n_sent++;
      end
      if (drv_gap > 0 || pending_words.size() == 0) begin
        req.valid <= 1'b0;
        if (drv_gap > 0) drv_gap <= drv_gap - 1;
      end else begin
        word_t w;
        w = pending_words.pop_front();
        req.valid <= 1'b1;
        req.cmd <= w.cmd;
        req.track <= w.track;
        req.key_or_query_time <= w.t;
        req.in_x <= w.x;
        req.in_y <= w.y;
        req.in_z <= w.z;
        drv_gap <= pick_gap();
      end
    end
  end

  // monitor with random backpressure
  int stall_left;
  always @(posedge clk) begin
    if (rst) begin
      rsp.ready <= 1'b0;
      stall_left <= 0;
    end else begin
      if (rsp.valid && rsp.ready) begin
        vec_out_t e;
        n_got++;
        if (expected_vals.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected word: x=%h y=%h z=%h st=%0d k=%0d",
            rsp.out_x, rsp.out_y, rsp.out_z, rsp.status, rsp.interp_kind);
        end else begin
          e = expected_vals.pop_front();
          case (e.kind)
            KIND_LIN: n_lin++;
            KIND_SPLINE: n_spl++;
            default: n_hold++;
          endcase
          if (e.status == ST_FULL) n_full++;
          if (e.status == ST_EMPTY) n_empty++;
          if (rsp.out_x !== e.x || rsp.out_y !== e.y || rsp.out_z !== e.z ||
              rsp.status !== e.status || rsp.interp_kind !== e.kind) begin
            errors++;
            if (errors <= 10)
              $display("mismatch #%0d: exp x=%h y=%h z=%h st=%0d k=%0d got x=%h y=%h z=%h st=%0d k=%0d",
                n_got, e.x, e.y, e.z, e.status, e.kind,
                rsp.out_x, rsp.out_y, rsp.out_z, rsp.status, rsp.interp_kind);
          end
        end
      end
      if (stall_left > 0) begin
        rsp.ready <= 1'b0;
        stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 9) < 3) begin
        rsp.ready <= 1'b0;
        stall_left <= pick_gap();
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  function automatic logic [31:0] rnd_val();
    case ($urandom_range(0, 5))
      0: return 32'h7fffffff;
      1: return 32'h80000000;
      2: return $urandom_range(0, 65536 * 4) - 65536 * 2;
      default: return $urandom;
    endcase
  endfunction

  task automatic put_word(word_t w);
    pending_words.insert(pending_words.size(), w);
  endtask

  task automatic add_word(logic [1:0] c, logic [3:0] tr, logic [31:0] t);
    put_word('{c, tr, t, rnd_val(), rnd_val(), rnd_val()});
  endtask

  initial begin
    int tr, nk, r;
    logic [31:0] tcur, tmax;
    errors = 0;
    n_sent = 0;
    n_got = 0;
    n_hold = 0;
    n_lin = 0;
    n_spl = 0;
    n_full = 0;
    n_empty = 0;
    foreach (kcnt[i]) kcnt[i] = 0;
    req.valid = 0;
    req.cmd = CMD_CLEAR;
    req.track = 0;
    req.key_or_query_time = 0;
    req.in_x = 0;
    req.in_y = 0;
    req.in_z = 0;
    rsp.ready = 0;
    rst = 1;
    repeat (11) @(posedge clk);
    rst <= 0;

    // directed: empty query, single key, equal times, out-of-order, extremes, unused cmd
    add_word(CMD_QUERY, 4'd0, 32'd0);
    add_word(CMD_NONE, 4'd15, 32'hffffffff);
    add_word(CMD_APPEND, 4'd15, 32'h00010000);
    add_word(CMD_QUERY, 4'd15, 32'd0);
    add_word(CMD_QUERY, 4'd15, 32'hffffffff);
    add_word(CMD_APPEND, 4'd15, 32'h00010000);
    add_word(CMD_APPEND, 4'd15, 32'h00008000);
    add_word(CMD_APPEND, 4'd15, 32'h00030000);
    add_word(CMD_APPEND, 4'd15, 32'hffffffff);
    add_word(CMD_QUERY, 4'd15, 32'h00010000);
    add_word(CMD_QUERY, 4'd15, 32'h00018000);
    add_word(CMD_QUERY, 4'd15, 32'h00028000);
    add_word(CMD_QUERY, 4'd15, 32'h80000000);
    put_word('{CMD_APPEND, 4'd3, 32'd0, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
    put_word('{CMD_APPEND, 4'd3, 32'd100, 32'h80000000, 32'h7fffffff, 32'h80000000});
    put_word('{CMD_APPEND, 4'd3, 32'd200, 32'h7fffffff, 32'h80000000, 32'h7fffffff});
    put_word('{CMD_APPEND, 4'd3, 32'd300, 32'h80000000, 32'h7fffffff, 32'h80000000});
    add_word(CMD_QUERY, 4'd3, 32'd150);
    add_word(CMD_QUERY, 4'd3, 32'd50);
    add_word(CMD_CLEAR, 4'd0, 32'd0);
    add_word(CMD_QUERY, 4'd3, 32'd150);

    // one track filled to overflow
    tcur = 0;
    for (int i = 0; i < NKEY + 3; i++) begin
      tcur += $urandom_range(0, 3000);
      add_word(CMD_APPEND, 4'd7, tcur);
    end
    for (int i = 0; i < 12; i++) add_word(CMD_QUERY, 4'd7, $urandom_range(0, tcur + 2000));

    // random: well-formed tracks with queries, plus noise
    while (pending_words.size() < 840) begin
      r = $urandom_range(0, 99);
      tr = $urandom_range(0, 15);
      if (r < 2) begin
        add_word(CMD_CLEAR, 4'($urandom), $urandom);
      end else if (r < 4) begin
        add_word(CMD_NONE, 4'($urandom), $urandom);
      end else if (r < 40) begin
        nk = $urandom_range(1, 6);
        tcur = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 1 << 20);
        for (int i = 0; i < nk; i++) begin
          add_word(CMD_APPEND, 4'(tr), ($urandom_range(0, 7) == 0) ? $urandom : tcur);
          tcur += ($urandom_range(0, 5) == 0) ? 0 : $urandom_range(1, 1 << 18);
        end
      end else begin
        tmax = tcur;
        add_word(CMD_QUERY, 4'(tr),
                 ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(0, tmax + 1000));
      end
    end

    while (pending_words.size() != 0 || req.valid || expected_vals.size() != 0)
      @(posedge clk);
    repeat (100) @(posedge clk);
    $display("sent %0d words, got %0d: hold %0d, linear %0d, spline %0d",
             n_sent, n_got, n_hold, n_lin, n_spl);
    $display("full-track drops %0d, empty-track queries %0d", n_full, n_empty);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches", errors);
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("timeout");
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[vec3_keyframe_spline_interp.f]
src/vksi_pkg.sv
src/vksi_req_if.sv
src/vksi_rsp_if.sv
src/vksi_ctrl.sv
src/vksi_dp.sv
src/vec3_keyframe_spline_interp.sv
tb/tb_top.sv
